[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the design checks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/ucc_pkg.sv]
// ----------------------------------------------------------------------------
// ucc_pkg
// Constants, types and helpers shared by the chunk collector modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ucc_pkg;

  // table geometry
  localparam int TABLE_ENTRIES   = 256;
  localparam int MAX_CHUNK_BYTES = 16;
  localparam int IDX_W           = $clog2(TABLE_ENTRIES);
  localparam int CNT_W           = $clog2(TABLE_ENTRIES + 1);

  // field widths
  localparam int HALF_W      = 64;
  localparam int CHUNK_BYTES = 16;
  localparam int CHUNK_W     = 2 * HALF_W;
  localparam int LEN_W       = 5;
  localparam int OUT_IDX_W   = 8;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(2);
  localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(2);
  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_CHUNK_BYTES);

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic take_hit;
    logic take_miss;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic miss;
    logic out_free;
  } status_t;

  // clamp the raw length register to the legal byte range
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] res;
    res = len;
    if (res < LEN_MIN) res = LEN_MIN;
    if (res > LEN_MAX) res = LEN_MAX;
    return res;
  endfunction

  // byte-granular mask covering the first len bytes
  function automatic logic [CHUNK_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    logic [CHUNK_W-1:0] m;
    m = '0;
    for (int b = 0; b < CHUNK_BYTES; b++) begin
      if (LEN_W'(b) < len) m[b*8 +: 8] = 8'hff;
    end
    return m;
  endfunction

endpackage

[hw/rtl/ucc_ctrl.sv]
// ----------------------------------------------------------------------------
// ucc_ctrl
// Sequencer for load, table scan, result capture and result hand-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ucc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  ucc_pkg::status_t sts,
  output ucc_pkg::cmd_t   cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;

  // input side is open only between items
  assign in_stall = (state_r != ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.hit) begin
          cmd.take_hit = 1'b1;
          state_nxt    = ST_EMIT;
        end else if (sts.miss) begin
          cmd.take_miss = 1'b1;
          state_nxt     = ST_EMIT;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hw/rtl/ucc_datapath.sv]
// ----------------------------------------------------------------------------
// ucc_datapath
// Entry memory, fill count, scan compare pipeline and result registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ucc_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic [ucc_pkg::LEN_W-1:0]           cfg_chunk_length,
  input  logic [ucc_pkg::HALF_W-1:0]          in_chunk_low,
  input  logic [ucc_pkg::HALF_W-1:0]          in_chunk_high,
  input  logic                                in_start_column,
  input  ucc_pkg::cmd_t                       cmd,
  output ucc_pkg::status_t                    sts,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_is_new,
  output logic [ucc_pkg::OUT_IDX_W-1:0]       out_entry_index,
  output logic                                out_table_full
);

  logic [ucc_pkg::CHUNK_W-1:0] mem [ucc_pkg::TABLE_ENTRIES];

  logic [ucc_pkg::LEN_W-1:0]   len_r;
  logic [ucc_pkg::CHUNK_W-1:0] key_r;
  logic [ucc_pkg::CHUNK_W-1:0] mask_r;
  logic [ucc_pkg::CHUNK_W-1:0] rd_data_r;
  logic [ucc_pkg::CNT_W-1:0]   count_r;
  logic [ucc_pkg::CNT_W-1:0]   rd_idx_r;
  logic [ucc_pkg::CNT_W-1:0]   cmp_idx_r;
  logic                        cmp_vld_r;
  logic                        res_new_r;
  logic                        res_full_r;
  logic [ucc_pkg::CNT_W-1:0]   res_idx_r;
  logic                        out_vld_r;
  logic                        out_new_r;
  logic                        out_full_r;
  logic [ucc_pkg::OUT_IDX_W-1:0] out_idx_r;

  logic [ucc_pkg::CHUNK_W-1:0] in_mask;
  logic                        rd_more;
  logic                        match;
  logic                        last_cmp;
  logic                        tbl_full;

  // mask for the incoming chunk from the clamped length
  assign in_mask = ucc_pkg::len_mask(ucc_pkg::eff_len(len_r));

  // scan status
  assign rd_more  = (rd_idx_r < count_r);
  assign match    = ((rd_data_r & mask_r) == key_r);
  assign last_cmp = ((cmp_idx_r + ucc_pkg::CNT_W'(1)) == count_r);
  assign tbl_full = (count_r == ucc_pkg::CNT_W'(ucc_pkg::TABLE_ENTRIES));

  assign sts.hit      = cmp_vld_r && match;
  assign sts.miss     = cmp_vld_r ? (!match && last_cmp) : !rd_more;
  assign sts.out_free = !out_vld_r || !out_stall;

  // length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= ucc_pkg::LEN_RESET;
    end else if (cfg_valid) begin
      len_r <= cfg_chunk_length;
    end
  end

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.take_miss && !tbl_full) begin
      mem[count_r[ucc_pkg::IDX_W-1:0]] <= key_r;
    end
    if (cmd.scan) begin
      rd_data_r <= mem[rd_idx_r[ucc_pkg::IDX_W-1:0]];
    end
  end

  // key capture and fill count
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r  <= {in_chunk_high, in_chunk_low} & in_mask;
      mask_r <= in_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.load && in_start_column) begin
      count_r <= '0;
    end else if (cmd.take_miss && !tbl_full) begin
      count_r <= count_r + ucc_pkg::CNT_W'(1);
    end
  end

  // scan read pointer and compare stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r  <= '0;
      cmp_vld_r <= 1'b0;
    end else if (cmd.load) begin
      rd_idx_r  <= '0;
      cmp_vld_r <= 1'b0;
    end else if (cmd.scan) begin
      cmp_vld_r <= rd_more;
      if (rd_more) rd_idx_r <= rd_idx_r + ucc_pkg::CNT_W'(1);
    end else begin
      cmp_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) cmp_idx_r <= rd_idx_r;
  end

  // result capture
  always_ff @(posedge clk) begin
    if (cmd.take_hit) begin
      res_new_r  <= 1'b0;
      res_full_r <= 1'b0;
      res_idx_r  <= cmp_idx_r;
    end else if (cmd.take_miss) begin
      res_new_r  <= 1'b1;
      res_full_r <= tbl_full;
      res_idx_r  <= tbl_full ? '0 : count_r;
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.emit) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_new_r  <= res_new_r;
      out_full_r <= res_full_r;
      out_idx_r  <= ucc_pkg::OUT_IDX_W'(res_idx_r);
    end
  end

  assign out_valid       = out_vld_r;
  assign out_is_new      = out_new_r;
  assign out_table_full  = out_full_r;
  assign out_entry_index = out_idx_r;

endmodule

[hw/rtl/unique_chunk_collector_core.sv]
// ----------------------------------------------------------------------------
// unique_chunk_collector_core
// Distinct-chunk table with first-appearance indexing for one pattern column
// ----------------------------------------------------------------------------
// Each input beat carries one chunk; the block scans its table of stored
// distinct chunks through a single-read-port memory, one entry per cycle, and
// returns one result beat: whether the chunk is new, its entry index, and a
// full flag when a new chunk could not be stored. The scan compares entries
// until a hit (or all stored entries on a miss), in a table of up to 256
// entries. The input is stalled while an item is in work, so a new chunk is
// accepted only after the last result is handed to the output register; a
// finished result waits there while the next chunk is accepted. start_column
// empties the table instantly, there is no clearing pass after reset.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module unique_chunk_collector_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ucc_pkg::LEN_W-1:0]     cfg_chunk_length,
  // chunk input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ucc_pkg::HALF_W-1:0]    in_chunk_low,
  input  logic [ucc_pkg::HALF_W-1:0]    in_chunk_high,
  input  logic                          in_start_column,
  // result output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_is_new,
  output logic [ucc_pkg::OUT_IDX_W-1:0] out_entry_index,
  output logic                          out_table_full
);

  ucc_pkg::cmd_t    cmd;
  ucc_pkg::status_t sts;

  assign cfg_ready = 1'b1;

  ucc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ucc_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_chunk_length (cfg_chunk_length),
    .in_chunk_low     (in_chunk_low),
    .in_chunk_high    (in_chunk_high),
    .in_start_column  (in_start_column),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_is_new       (out_is_new),
    .out_entry_index  (out_entry_index),
    .out_table_full   (out_table_full)
  );

  // checks
  `ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input open while busy")
  `ASSERT_SAME(a_full_is_new, out_valid && out_table_full, out_is_new, "full without new")
  `ASSERT_SAME(a_full_idx_zero, out_valid && out_table_full, out_entry_index == '0, "full idx")
  `ASSERT_SAME(a_one_take, cmd.take_hit, !cmd.take_miss, "hit and miss together")

endmodule
